>>> sv/cepa_an_pkg.sv
// Shared types and constants for the amplitude normalizer.
// Used by the channel interfaces, the iterative divide/root unit and the top level.
// No dependencies.
package cepa_an_pkg;

    // Default store sizing
    localparam int DEF_MAX_OCCUPIED = 8;
    localparam int DEF_MAX_VIRTUAL  = 16;

    // Field widths of the channels
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 14;
    localparam int AMP_W   = 32;

    // Fixed point one in Q2.29
    localparam logic [31:0] ONE_Q29 = 32'h2000_0000;

    // Numerator width of the long divider: 2^98 needs 99 bits
    localparam int NUM_W      = 99;
    localparam int SQRT_STEPS = 32;
    localparam int ITER_CW    = $clog2(NUM_W + 1);

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_OCCUPIED  = 2'd0;
    localparam logic [1:0] REG_VIRTUAL   = 2'd1;
    localparam logic [1:0] REG_PAIR_MODE = 2'd2;

    // Request mode codes
    typedef enum logic [2:0] {
        MODE_WR_DOUBLES = 3'd0,
        MODE_WR_SINGLES = 3'd1,
        MODE_FINISH     = 3'd2,
        MODE_RD_DOUBLES = 3'd3,
        MODE_RD_SINGLES = 3'd4
    } t_mode;

    // Pair mode codes
    typedef enum logic [1:0] {
        PAIR_NONE  = 2'd0,
        PAIR_ONE   = 2'd1,
        PAIR_INV_O = 2'd2,
        PAIR_COUNT = 2'd3
    } t_pair_mode;

    // Iterative unit operation
    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic             go;
        t_iter_op         op;
        logic [NUM_W-1:0] num;
        logic [63:0]      den;
    } t_iter_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_iter_rsp;

    // Top level sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_MUL,
        ST_RD_DONE,
        ST_DT,
        ST_DP,
        ST_DQ,
        ST_DM1,
        ST_DM2,
        ST_DM3,
        ST_ST,
        ST_SW,
        ST_SM,
        ST_SA,
        ST_N1,
        ST_N2,
        ST_N3,
        ST_N4,
        ST_GO1,
        ST_W1,
        ST_GO2,
        ST_W2,
        ST_GO3,
        ST_W3,
        ST_OUT
    } t_state;

endpackage

>>> sv/cepa_an_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on cepa_an_pkg for field widths.
interface cepa_an_in_if
    import cepa_an_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        element_index;
    logic signed [AMP_W-1:0]   amplitude;

    modport source (output valid, mode, element_index, amplitude, input ready);
    modport sink   (input valid, mode, element_index, amplitude, output ready);
endinterface

interface cepa_an_out_if
    import cepa_an_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [AMP_W-1:0]   result_value;
    logic                      is_coefficient;

    modport source (output valid, result_value, is_coefficient, input ready);
    modport sink   (input valid, result_value, is_coefficient, output ready);
endinterface

>>> sv/cepa_an_iter.sv
// Iterative long divider and integer square root, one step per cycle.
// Depends on cepa_an_pkg (request/response structs, op codes).
module cepa_an_iter
    import cepa_an_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_req i_req,
    output t_iter_rsp o_rsp
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_iter_op           r_op, n_op;
    logic [ITER_CW-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [63:0]        r_den, n_den;
    logic [64:0]        r_rem, n_rem;
    logic [63:0]        r_quo, n_quo;
    logic [63:0]        r_x, n_x;
    logic [63:0]        r_root, n_root;
    logic [63:0]        r_bit, n_bit;

    logic [64:0]        rem_sh;
    logic [64:0]        trial;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_x    <= n_x;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    // Trial values for one step of each operation
    assign rem_sh = {r_rem[63:0], r_num[NUM_W-1]};
    assign trial  = {1'b0, r_root} + {1'b0, r_bit};

    // Step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_x    = r_x;
        n_root = r_root;
        n_bit  = r_bit;
        if (!r_busy) begin
            if (i_req.go) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_num  = i_req.num;
                n_den  = i_req.den;
                n_rem  = '0;
                n_quo  = '0;
                n_x    = i_req.num[63:0];
                n_root = '0;
                n_bit  = 64'h4000_0000_0000_0000;
                n_cnt  = (i_req.op == OP_DIV) ? ITER_CW'(NUM_W) : ITER_CW'(SQRT_STEPS);
            end
        end else begin
            if (r_op == OP_DIV) begin
                // restoring division, one quotient bit
                n_num = r_num << 1;
                if (rem_sh >= {1'b0, r_den}) begin
                    n_rem = rem_sh - {1'b0, r_den};
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end else begin
                // digit-by-digit root, one result bit
                if ({1'b0, r_x} >= trial) begin
                    n_x    = r_x - trial[63:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ITER_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == OP_DIV) ? r_quo : r_root;

endmodule

>>> sv/cepa_amplitude_normalizer_unit.sv
// Amplitude normalizer. Write requests (doubles or singles) go into their store as they are
// accepted. A read request passes through store read, multiply by the kept coefficient,
// rounding and the output register. A finish request walks the active stores through one
// shared 33x33 multiplier, each doubles element (o*o*v*v of them) with its a/b partner and
// then each singles element (o*v), scales the sum and drives an iterative divide/root unit
// at one bit per cycle for the pair factor, the reciprocal and the root. With pair mode
// zero a finish returns one without walking the stores. The block takes one request at a
// time; a finished result waits in the output register. The stores need no clearing after
// reset.
// Depends on cepa_an_pkg, cepa_an_if and cepa_an_iter.
module cepa_amplitude_normalizer_unit
    import cepa_an_pkg::*;
#(
    parameter int MAX_OCCUPIED = DEF_MAX_OCCUPIED,
    parameter int MAX_VIRTUAL  = DEF_MAX_VIRTUAL
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cepa_an_in_if.sink   i_req,
    cepa_an_out_if.source o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DDEPTH = MAX_OCCUPIED * MAX_OCCUPIED * MAX_VIRTUAL * MAX_VIRTUAL;
    localparam int SDEPTH = MAX_OCCUPIED * MAX_VIRTUAL;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int DCW    = $clog2(DDEPTH + 1);
    localparam int SCW    = $clog2(SDEPTH + 1);
    localparam int OW     = $clog2(MAX_OCCUPIED + 1);
    localparam int VW     = $clog2(MAX_VIRTUAL + 1);
    localparam int OOW    = $clog2(MAX_OCCUPIED * MAX_OCCUPIED + 1);
    localparam int NW     = $clog2(4 * MAX_OCCUPIED);
    localparam int DW     = $clog2(MAX_OCCUPIED * (2 * MAX_OCCUPIED - 1) + 1);

    // Configuration registers
    logic [3:0] r_occ;
    logic [4:0] r_virt;
    logic [1:0] r_pmode;

    // Stores
    logic [31:0] mem_d [DDEPTH];
    logic [31:0] mem_s [SDEPTH];
    logic [31:0] r_drd, r_srd;
    logic [DAW-1:0] d_raddr;
    logic [SAW-1:0] s_raddr;

    // Sequencer and datapath
    t_state          r_state, n_state;
    logic [31:0]     r_coef, n_coef;
    logic            r_ovalid, n_ovalid;
    logic [31:0]     r_odata, n_odata;
    logic            r_ocoef, n_ocoef;
    logic [31:0]     r_res, n_res;
    logic            r_rcoef, n_rcoef;
    logic            r_sel_s, n_sel_s;
    logic            r_oor, n_oor;
    logic            r_neg, n_neg;
    logic [32:0]     r_ma, n_ma;
    logic [32:0]     r_mb, n_mb;
    logic [65:0]     r_prod;
    logic [31:0]     r_t, n_t;
    logic [32:0]     r_dm, n_dm;
    logic [63:0]     r_sum, n_sum;
    logic [NUM_W-1:0] r_num, n_num;
    logic [63:0]     r_xden, n_xden;
    logic [63:0]     r_sq, n_sq;
    logic [VW-1:0]   r_v, n_v;
    logic [OOW-1:0]  r_oo, n_oo;
    logic [DCW-1:0]  r_vstride, n_vstride;
    logic [SCW-1:0]  r_ov, n_ov;
    logic [NW-1:0]   r_n, n_n;
    logic [DW-1:0]   r_d, n_d;
    logic [VW-1:0]   r_ca, n_ca;
    logic [VW-1:0]   r_cb, n_cb;
    logic [OOW-1:0]  r_cij, n_cij;
    logic [DCW-1:0]  r_id, n_id;
    logic [DCW-1:0]  r_pbase, n_pbase;
    logic [DCW-1:0]  r_abase, n_abase;
    logic [SCW-1:0]  r_sid, n_sid;

    logic            accept;
    logic [31:0]     idx32;
    logic [31:0]     occ32, virt32;
    logic [OW-1:0]   o_cl;
    logic [VW-1:0]   v_cl;
    logic [DCW-1:0]  pid;
    logic [31:0]     rd_word;
    logic [65:0]     rd_q;
    logic [64:0]     x_sum;
    logic            cfg_wr;
    t_iter_req       iter_req;
    t_iter_rsp       iter_rsp;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (33'd0 - d) : d;
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 4'd1;
            r_virt  <= 5'd1;
            r_pmode <= PAIR_ONE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OCCUPIED:  r_occ   <= pwdata[3:0];
                REG_VIRTUAL:   r_virt  <= pwdata[4:0];
                REG_PAIR_MODE: r_pmode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OCCUPIED:  prdata = 32'(r_occ);
            REG_VIRTUAL:   prdata = 32'(r_virt);
            REG_PAIR_MODE: prdata = 32'(r_pmode);
            default:       prdata = '0;
        endcase
    end

    // Clamped counts
    assign occ32  = 32'(r_occ);
    assign virt32 = 32'(r_virt);
    assign o_cl   = OW'((occ32 == 0) ? 1 : ((occ32 > MAX_OCCUPIED) ? MAX_OCCUPIED : occ32));
    assign v_cl   = VW'((virt32 == 0) ? 1 : ((virt32 > MAX_VIRTUAL) ? MAX_VIRTUAL : virt32));

    // Request handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign idx32       = 32'(i_req.element_index);

    // Store addressing
    assign pid     = r_pbase + DCW'(r_cij);
    assign d_raddr = (r_state == ST_IDLE) ? idx32[DAW-1:0] :
                     (r_state == ST_DT)   ? r_id[DAW-1:0]  : pid[DAW-1:0];
    assign s_raddr = (r_state == ST_IDLE) ? idx32[SAW-1:0] : r_sid[SAW-1:0];

    // Doubles store
    always_ff @(posedge i_clk) begin
        if (accept && (t_mode'(i_req.mode) == MODE_WR_DOUBLES) && (idx32 < DDEPTH)) begin
            mem_d[idx32[DAW-1:0]] <= i_req.amplitude;
        end
        r_drd <= mem_d[d_raddr];
    end

    // Singles store
    always_ff @(posedge i_clk) begin
        if (accept && (t_mode'(i_req.mode) == MODE_WR_SINGLES) && (idx32 < SDEPTH)) begin
            mem_s[idx32[SAW-1:0]] <= i_req.amplitude;
        end
        r_srd <= mem_s[s_raddr];
    end

    // Shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    // Divide/root unit
    always_comb begin
        iter_req.go  = (r_state == ST_GO1) || (r_state == ST_GO2) || (r_state == ST_GO3);
        iter_req.op  = (r_state == ST_GO3) ? OP_SQRT : OP_DIV;
        iter_req.num = (r_state == ST_GO1) ? r_num :
                       (r_state == ST_GO2) ? (NUM_W'(1) << (NUM_W - 1)) : NUM_W'(r_sq);
        iter_req.den = (r_state == ST_GO1) ? 64'(r_d) : r_xden;
    end

    cepa_an_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    // Read scaling and reciprocal argument
    assign rd_word = r_sel_s ? r_srd : r_drd;
    assign rd_q    = r_neg ? ((r_prod + 66'(ONE_Q29 - 32'd1)) >> 29) : (r_prod >> 29);
    assign x_sum   = {1'b0, iter_rsp.result} + 65'h100_0000_0000;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_coef   <= ONE_Q29;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_coef   <= n_coef;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_odata   <= n_odata;
        r_ocoef   <= n_ocoef;
        r_res     <= n_res;
        r_rcoef   <= n_rcoef;
        r_sel_s   <= n_sel_s;
        r_oor     <= n_oor;
        r_neg     <= n_neg;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_t       <= n_t;
        r_dm      <= n_dm;
        r_sum     <= n_sum;
        r_num     <= n_num;
        r_xden    <= n_xden;
        r_sq      <= n_sq;
        r_v       <= n_v;
        r_oo      <= n_oo;
        r_vstride <= n_vstride;
        r_ov      <= n_ov;
        r_n       <= n_n;
        r_d       <= n_d;
        r_ca      <= n_ca;
        r_cb      <= n_cb;
        r_cij     <= n_cij;
        r_id      <= n_id;
        r_pbase   <= n_pbase;
        r_abase   <= n_abase;
        r_sid     <= n_sid;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_coef    = r_coef;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_odata   = r_odata;
        n_ocoef   = r_ocoef;
        n_res     = r_res;
        n_rcoef   = r_rcoef;
        n_sel_s   = r_sel_s;
        n_oor     = r_oor;
        n_neg     = r_neg;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_t       = r_t;
        n_dm      = r_dm;
        n_sum     = r_sum;
        n_num     = r_num;
        n_xden    = r_xden;
        n_sq      = r_sq;
        n_v       = r_v;
        n_oo      = r_oo;
        n_vstride = r_vstride;
        n_ov      = r_ov;
        n_n       = r_n;
        n_d       = r_d;
        n_ca      = r_ca;
        n_cb      = r_cb;
        n_cij     = r_cij;
        n_id      = r_id;
        n_pbase   = r_pbase;
        n_abase   = r_abase;
        n_sid     = r_sid;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_req.mode))
                        MODE_FINISH: begin
                            if (r_pmode == PAIR_NONE) begin
                                n_coef  = ONE_Q29;
                                n_res   = ONE_Q29;
                                n_rcoef = 1'b1;
                                n_state = ST_OUT;
                            end else begin
                                n_v       = v_cl;
                                n_oo      = OOW'(32'(o_cl) * 32'(o_cl));
                                n_vstride = DCW'(32'(v_cl) * 32'(o_cl) * 32'(o_cl));
                                n_ov      = SCW'(32'(o_cl) * 32'(v_cl));
                                case (t_pair_mode'(r_pmode))
                                    PAIR_INV_O: begin
                                        n_n = NW'(1);
                                        n_d = DW'(o_cl);
                                    end
                                    PAIR_COUNT: begin
                                        n_n = NW'(4 * 32'(o_cl) - 3);
                                        n_d = DW'(32'(o_cl) * (2 * 32'(o_cl) - 1));
                                    end
                                    default: begin
                                        n_n = NW'(1);
                                        n_d = DW'(1);
                                    end
                                endcase
                                n_sum   = '0;
                                n_ca    = '0;
                                n_cb    = '0;
                                n_cij   = '0;
                                n_id    = '0;
                                n_pbase = '0;
                                n_abase = '0;
                                n_sid   = '0;
                                n_state = ST_DT;
                            end
                        end
                        MODE_RD_DOUBLES: begin
                            n_sel_s = 1'b0;
                            n_oor   = !(idx32 < DDEPTH);
                            n_state = ST_RD_WAIT;
                        end
                        MODE_RD_SINGLES: begin
                            n_sel_s = 1'b1;
                            n_oor   = !(idx32 < SDEPTH);
                            n_state = ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end

            // Read: scale the stored amplitude by the coefficient
            ST_RD_WAIT: begin
                n_neg   = rd_word[31];
                n_ma    = 33'(mag32(rd_word));
                n_mb    = 33'(r_coef);
                n_state = ST_RD_MUL;
            end
            ST_RD_MUL: begin
                n_state = ST_RD_DONE;
            end
            ST_RD_DONE: begin
                n_res   = r_oor ? 32'd0 : (r_neg ? (32'd0 - rd_q[31:0]) : rd_q[31:0]);
                n_rcoef = 1'b0;
                n_state = ST_OUT;
            end

            // Doubles walk: element, then its a/b partner
            ST_DT: begin
                n_state = ST_DP;
            end
            ST_DP: begin
                n_t     = r_drd;
                n_state = ST_DQ;
            end
            ST_DQ: begin
                n_ma    = 33'(mag32(r_t));
                n_mb    = 33'(mag32(r_t));
                n_dm    = absdiff(r_t, r_drd);
                n_state = ST_DM1;
            end
            ST_DM1: begin
                n_ma    = r_dm;
                n_mb    = r_dm;
                n_state = ST_DM2;
            end
            ST_DM2: begin
                n_sum   = sat_add64(r_sum, 64'(r_prod[65:18]));
                n_state = ST_DM3;
            end
            ST_DM3: begin
                n_sum = sat_add64(r_sum, 64'(r_prod[65:19]));
                n_id  = r_id + 1'b1;
                if (r_cij == r_oo - 1'b1) begin
                    n_cij = '0;
                    if (r_cb == r_v - 1'b1) begin
                        n_cb    = '0;
                        n_ca    = r_ca + 1'b1;
                        n_abase = r_abase + DCW'(r_oo);
                        n_pbase = r_abase + DCW'(r_oo);
                    end else begin
                        n_cb    = r_cb + 1'b1;
                        n_pbase = r_pbase + r_vstride;
                    end
                end else begin
                    n_cij = r_cij + 1'b1;
                end
                if ((r_cij == r_oo - 1'b1) && (r_cb == r_v - 1'b1) && (r_ca == r_v - 1'b1)) begin
                    n_state = ST_ST;
                end else begin
                    n_state = ST_DT;
                end
            end

            // Singles walk; a singles term is at most 2^45, no clipping needed
            ST_ST: begin
                n_state = ST_SW;
            end
            ST_SW: begin
                n_ma    = 33'(mag32(r_srd));
                n_mb    = 33'(mag32(r_srd));
                n_state = ST_SM;
            end
            ST_SM: begin
                n_state = ST_SA;
            end
            ST_SA: begin
                n_sum = sat_add64(r_sum, 64'(r_prod[65:17]));
                if (r_sid == r_ov - 1'b1) begin
                    n_state = ST_N1;
                end else begin
                    n_sid   = r_sid + 1'b1;
                    n_state = ST_ST;
                end
            end

            // Sum times pair numerator, in two 32-bit halves
            ST_N1: begin
                n_ma    = 33'(r_sum[31:0]);
                n_mb    = 33'(r_n);
                n_state = ST_N2;
            end
            ST_N2: begin
                n_ma    = 33'(r_sum[63:32]);
                n_state = ST_N3;
            end
            ST_N3: begin
                n_num   = NUM_W'(r_prod);
                n_state = ST_N4;
            end
            ST_N4: begin
                n_num   = r_num + (NUM_W'(r_prod) << 32);
                n_state = ST_GO1;
            end

            // Divide by pair denominator, reciprocal, root
            ST_GO1: begin
                n_state = ST_W1;
            end
            ST_W1: begin
                if (iter_rsp.done) begin
                    n_xden  = x_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : x_sum[63:0];
                    n_state = ST_GO2;
                end
            end
            ST_GO2: begin
                n_state = ST_W2;
            end
            ST_W2: begin
                if (iter_rsp.done) begin
                    n_sq    = iter_rsp.result;
                    n_state = ST_GO3;
                end
            end
            ST_GO3: begin
                n_state = ST_W3;
            end
            ST_W3: begin
                if (iter_rsp.done) begin
                    n_coef  = iter_rsp.result[31:0];
                    n_res   = iter_rsp.result[31:0];
                    n_rcoef = 1'b1;
                    n_state = ST_OUT;
                end
            end

            // Hand the result to the output register
            ST_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_ocoef  = r_rcoef;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.result_value   = r_odata;
    assign o_rsp.is_coefficient = r_ocoef;

`ifndef SYNTHESIS
    // A returned coefficient lies in (0, 1]
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ocoef) |-> ((r_odata != 32'd0) && (r_odata <= ONE_Q29)))
        else $error("coefficient out of range");

    // Walk addresses stay inside the doubles store
    a_walk_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DT) |-> (32'(r_id) < DDEPTH))
        else $error("doubles walk address out of range");

    a_partner_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DP) |-> (32'(pid) < DDEPTH))
        else $error("partner address out of range");

    // The divide/root unit only finishes while the sequencer waits on it
    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_rsp.done |-> ((r_state == ST_W1) || (r_state == ST_W2) || (r_state == ST_W3)))
        else $error("unexpected divide/root completion");
`endif

endmodule

>>> sim/cepa_amplitude_normalizer_unit_tb.sv
// Testbench for cepa_amplitude_normalizer_unit: loads, reads and finish requests
// checked against an in-bench predictor over several register settings and stall patterns.
// Depends on cepa_an_pkg, cepa_an_if and the top level RTL.
`timescale 1ns / 100ps

module cepa_amplitude_normalizer_unit_tb;
    import cepa_an_pkg::*;

    localparam int          DBL_DEPTH   = DEF_MAX_OCCUPIED * DEF_MAX_OCCUPIED *
                                          DEF_MAX_VIRTUAL * DEF_MAX_VIRTUAL;
    localparam int          SGL_DEPTH   = DEF_MAX_OCCUPIED * DEF_MAX_VIRTUAL;
    localparam logic [2:0]  MODE_UNUSED = 3'd5;
    localparam int          STALL_LIMIT = 150000;
    localparam int          SETTLE      = 20;

    typedef struct packed {
        logic [31:0] value;
        logic        coef_flag;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    cepa_an_in_if  req_if ();
    cepa_an_out_if rsp_if ();

    cepa_amplitude_normalizer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state
    logic [31:0] dbl_amp [DBL_DEPTH];
    logic [31:0] sgl_amp [SGL_DEPTH];
    bit          dbl_written [DBL_DEPTH];
    bit          sgl_written [SGL_DEPTH];
    int          dbl_written_list[$];
    logic [31:0] lead_coef;
    logic [3:0]  cfg_occ;
    logic [4:0]  cfg_virt;
    logic [1:0]  cfg_pair;

    t_result     expected_results[$];
    int          error_count;
    int          mismatch_count;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          rcv_hold_cycles;
    int          quiet_cycles;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Arithmetic helpers
    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int clamp_count(int c, int hi);
        if (c < 1) return 1;
        return c > hi ? hi : c;
    endfunction

    // Leading coefficient from the active part of both stores
    function automatic logic [31:0] norm_coefficient();
        int                  o, v, id;
        logic signed [63:0]  t, p;
        logic [63:0]         m, dm, s, n, d, scaled, x, root;
        logic [127:0]        q;
        o = clamp_count(cfg_occ, DEF_MAX_OCCUPIED);
        v = clamp_count(cfg_virt, DEF_MAX_VIRTUAL);
        s = 0;
        id = 0;
        if (cfg_pair == PAIR_NONE) return ONE_Q29;
        for (int a = 0; a < v; a++)
            for (int b = 0; b < v; b++)
                for (int i = 0; i < o; i++)
                    for (int j = 0; j < o; j++) begin
                        t  = $signed(dbl_amp[id]);
                        p  = $signed(dbl_amp[((b * v + a) * o + i) * o + j]);
                        m  = abs64(t);
                        dm = abs64(t - p);
                        s  = sat_sum(s, (m * m) >> 18);
                        s  = sat_sum(s, (dm * dm) >> 19);
                        id++;
                    end
        for (int k = 0; k < o * v; k++) begin
            m = abs64($signed(sgl_amp[k]));
            s = sat_sum(s, (m * m) >> 17);
        end
        if (cfg_pair == PAIR_INV_O) begin
            n = 1;
            d = o;
        end else if (cfg_pair == PAIR_COUNT) begin
            n = 4 * o - 3;
            d = o * (2 * o - 1);
        end else begin
            n = 1;
            d = 1;
        end
        scaled = (s / d) * n + ((s % d) * n) / d;
        x = sat_sum(64'h1 << 40, scaled);
        q = (128'h1 << 98) / {64'h0, x};
        root = int_sqrt(q[63:0]);
        return root[31:0];
    endfunction

    // Stored amplitude times the kept coefficient, floored
    function automatic logic [31:0] scaled_amplitude(logic [31:0] raw);
        logic signed [63:0] t;
        logic [63:0]        p, q;
        t = $signed(raw);
        p = abs64(t) * {32'h0, lead_coef};
        if (t < 0) begin
            q = (p + (ONE_Q29 - 1)) >> 29;
            return 32'h0 - q[31:0];
        end
        q = p >> 29;
        return q[31:0];
    endfunction

    // Update the predictor for one accepted request
    task automatic predict_request(logic [2:0] mode, logic [13:0] idx, logic [31:0] amp);
        t_result r;
        case (mode)
            MODE_WR_DOUBLES: begin
                dbl_amp[idx] = amp;
                if (!dbl_written[idx]) dbl_written_list.push_back(idx);
                dbl_written[idx] = 1'b1;
            end
            MODE_WR_SINGLES: begin
                if (idx < SGL_DEPTH) begin
                    sgl_amp[idx] = amp;
                    sgl_written[idx] = 1'b1;
                end
            end
            MODE_FINISH: begin
                lead_coef = norm_coefficient();
                r.value = lead_coef;
                r.coef_flag = 1'b1;
                expected_results.push_back(r);
            end
            MODE_RD_DOUBLES: begin
                r.value = scaled_amplitude(dbl_amp[idx]);
                r.coef_flag = 1'b0;
                expected_results.push_back(r);
            end
            MODE_RD_SINGLES: begin
                r.value = idx < SGL_DEPTH ? scaled_amplitude(sgl_amp[idx]) : 32'h0;
                r.coef_flag = 1'b0;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Send one request, with a random gap first; returns just after the accepting edge
    task automatic send_request(logic [2:0] mode, logic [13:0] idx, logic [31:0] amp);
        bit rdy;
        if ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.element_index <= idx;
        req_if.amplitude     <= amp;
        do begin
            @(negedge i_clk);
            rdy = req_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        predict_request(mode, idx, amp);
    endtask

    // Drop valid and wait until every result is back and the block has settled
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write: setup then access cycle
    task automatic reg_write(logic [1:0] reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_OCCUPIED:  cfg_occ  = value[3:0];
            REG_VIRTUAL:   cfg_virt = value[4:0];
            REG_PAIR_MODE: cfg_pair = value[1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_amplitude();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Directed corners at reset settings (o = 1, v = 1, factor one)
    task automatic test_directed();
        send_request(MODE_WR_DOUBLES, 14'd0, 32'h7FFF_FFFF);
        send_request(MODE_RD_DOUBLES, 14'd0, 32'h0);
        send_request(MODE_WR_SINGLES, 14'd0, 32'h8000_0000);
        send_request(MODE_RD_SINGLES, 14'd0, 32'h0);
        send_request(MODE_WR_DOUBLES, 14'h3FFF, 32'h8000_0000);
        send_request(MODE_RD_DOUBLES, 14'h3FFF, 32'hFFFF_FFFF);
        send_request(MODE_WR_SINGLES, 14'd127, 32'h0);
        send_request(MODE_RD_SINGLES, 14'd127, 32'h0);
        // out-of-range singles index: write ignored, read gives zero
        send_request(MODE_WR_SINGLES, 14'h3FFF, 32'h1234_5678);
        send_request(MODE_RD_SINGLES, 14'h3FFF, 32'h0);
        // unused mode codes, no result
        for (int k = MODE_UNUSED; k < 8; k++) send_request(3'(k), 14'h2AAA, 32'h5555_AAAA);
        send_request(MODE_FINISH, 14'd0, 32'h0);
        send_request(MODE_RD_DOUBLES, 14'h3FFF, 32'h0);
        send_request(MODE_RD_SINGLES, 14'd0, 32'h0);
        send_request(MODE_WR_DOUBLES, 14'd0, 32'h0);
        send_request(MODE_FINISH, 14'd0, 32'h0);
        send_request(MODE_FINISH, 14'd0, 32'h0);
        drain();
    endtask

    // One register setting: fill the active region (unless pair mode is none), then random traffic
    task automatic test_setting(int occ, int virt, int pair, int n_items);
        int       o, v, dbl_span, r, idx;
        o = clamp_count(occ, DEF_MAX_OCCUPIED);
        v = clamp_count(virt, DEF_MAX_VIRTUAL);
        dbl_span = o * o * v * v;
        reg_write(REG_OCCUPIED, occ);
        reg_write(REG_VIRTUAL, virt);
        reg_write(REG_PAIR_MODE, pair);
        if (pair != PAIR_NONE) begin
            for (int k = 0; k < dbl_span; k++)
                if (!dbl_written[k]) send_request(MODE_WR_DOUBLES, 14'(k), rand_amplitude());
            for (int k = 0; k < o * v; k++)
                if (!sgl_written[k]) send_request(MODE_WR_SINGLES, 14'(k), rand_amplitude());
        end
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                idx = ($urandom_range(9) < 8) ? $urandom_range(dbl_span - 1)
                                              : $urandom_range(DBL_DEPTH - 1);
                send_request(MODE_WR_DOUBLES, 14'(idx), rand_amplitude());
            end else if (r < 42) begin
                idx = ($urandom_range(9) < 8) ? $urandom_range(o * v - 1)
                                              : $urandom_range(DBL_DEPTH - 1);
                send_request(MODE_WR_SINGLES, 14'(idx), rand_amplitude());
            end else if (r < 70) begin
                idx = dbl_written_list[$urandom_range(dbl_written_list.size() - 1)];
                send_request(MODE_RD_DOUBLES, 14'(idx), $urandom);
            end else if (r < 84) begin
                idx = $urandom_range(DBL_DEPTH - 1);
                if ($urandom_range(1)) idx = $urandom_range(SGL_DEPTH - 1);
                if (idx < SGL_DEPTH && !sgl_written[idx]) idx = 0;
                send_request(MODE_RD_SINGLES, 14'(idx), $urandom);
            end else if (r < 92 && pair != PAIR_NONE) begin
                send_request(MODE_FINISH, 14'($urandom), $urandom);
            end else if (r < 92) begin
                send_request(MODE_FINISH, 14'd0, 32'h0);
            end else begin
                send_request(3'($urandom_range(7, MODE_UNUSED)), 14'($urandom), $urandom);
            end
        end
        drain();
    endtask

    // Receiver holds off while reads pile up, then the sender waits for everything
    task automatic test_backpressure();
        int idx;
        rcv_hold_cycles = 300;
        for (int n = 0; n < 24; n++) begin
            idx = dbl_written_list[$urandom_range(dbl_written_list.size() - 1)];
            send_request(MODE_RD_DOUBLES, 14'(idx), 32'h0);
        end
        send_request(MODE_FINISH, 14'd0, 32'h0);
        drain();
        send_request(MODE_RD_SINGLES, 14'd0, 32'h0);
        drain();
    endtask

    // Receiver: random ready, compare each accepted result with the oldest expectation
    initial begin
        t_result exp_r;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rcv_hold_cycles > 0) begin
                rcv_hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
            @(negedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("unexpected result value=%h coef=%b",
                                 rsp_if.result_value, rsp_if.is_coefficient);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (rsp_if.result_value !== exp_r.value ||
                        rsp_if.is_coefficient !== exp_r.coef_flag) begin
                        error_count++;
                        if (mismatch_count++ < 10)
                            $display("mismatch: expected value=%h coef=%b, got value=%h coef=%b",
                                     exp_r.value, exp_r.coef_flag,
                                     rsp_if.result_value, rsp_if.is_coefficient);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    initial begin
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL cepa_amplitude_normalizer_unit");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        error_count     = 0;
        mismatch_count  = 0;
        rcv_hold_cycles = 0;
        snd_idle_pct    = 14;
        rcv_idle_pct    = 60;
        lead_coef       = ONE_Q29;
        cfg_occ         = 4'd1;
        cfg_virt        = 5'd1;
        cfg_pair        = PAIR_ONE;
        for (int k = 0; k < DBL_DEPTH; k++) dbl_amp[k] = 32'h0;
        for (int k = 0; k < SGL_DEPTH; k++) sgl_amp[k] = 32'h0;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= 4'h0;
        pwdata               <= 32'h0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= MODE_WR_DOUBLES;
        req_if.element_index <= 14'h0;
        req_if.amplitude     <= 32'sh0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_setting(2, 3, PAIR_COUNT, 150);
        test_setting(8, 1, PAIR_INV_O, 110);
        snd_idle_pct = 60;
        rcv_idle_pct = 14;
        test_setting(1, 16, PAIR_COUNT, 110);
        test_setting(3, 2, PAIR_ONE, 90);
        test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_setting(0, 0, PAIR_INV_O, 80);
        test_setting(8, 16, PAIR_NONE, 80);
        test_setting(15, 31, PAIR_NONE, 50);
        test_setting(4, 4, PAIR_COUNT, 110);
        test_setting(1, 1, PAIR_ONE, 50);

        drain();
        if (error_count == 0)
            $display("PASS cepa_amplitude_normalizer_unit");
        else
            $display("FAIL cepa_amplitude_normalizer_unit");
        $finish;
    end

endmodule
